>>> hdl/ttl_kvt_pkg.sv
// ttl_kvt_pkg: shared types, codes and constants for the TTL key/value table.
// Used by the channel interfaces, the slot memory and the core top level.
// No dependencies.
package ttl_kvt_pkg;

    // Field widths and default table size
    localparam int KEY_W         = 32;
    localparam int VALUE_W       = 32;
    localparam int TIME_W        = 32;
    localparam int TABLE_ENTRIES = 16;

    // Request operation codes
    typedef enum logic [0:0] {
        OP_PUT = 1'b0,
        OP_GET = 1'b1
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_HIT    = 2'd0,
        STAT_MISS   = 2'd1,
        STAT_STORED = 2'd2,
        STAT_FULL   = 2'd3
    } status_t;

    // Value returned on anything other than a get hit
    localparam logic [VALUE_W-1:0] NO_VALUE = '1;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_FINISH
    } state_t;

    // One row of the slot memory
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [TIME_W-1:0]  expiry;
    } slot_row_t;

endpackage

>>> hdl/ttl_kvt_req_if.sv
// ttl_kvt_req_if: request channel (put/get words) with valid/ready handshake.
// Depends on ttl_kvt_pkg for field widths.
interface ttl_kvt_req_if;

    logic                                   valid;
    logic                                   ready;
    logic                                   operation;
    logic signed [ttl_kvt_pkg::KEY_W-1:0]   entry_key;
    logic signed [ttl_kvt_pkg::VALUE_W-1:0] entry_value;
    logic [ttl_kvt_pkg::TIME_W-1:0]         expiry_time;
    logic [ttl_kvt_pkg::TIME_W-1:0]         current_time;

    modport source (
        output valid, operation, entry_key, entry_value, expiry_time, current_time,
        input  ready
    );

    modport sink (
        input  valid, operation, entry_key, entry_value, expiry_time, current_time,
        output ready
    );

endinterface

>>> hdl/ttl_kvt_rsp_if.sv
// ttl_kvt_rsp_if: result channel (status and read value) with valid/ready handshake.
// Depends on ttl_kvt_pkg for field widths.
interface ttl_kvt_rsp_if;

    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             status;
    logic signed [ttl_kvt_pkg::VALUE_W-1:0] read_value;

    modport source (
        output valid, status, read_value,
        input  ready
    );

    modport sink (
        input  valid, status, read_value,
        output ready
    );

endinterface

>>> hdl/ttl_kvt_slot_ram.sv
// ttl_kvt_slot_ram: slot store, one write port and one read port, registered read data.
// Depends on ttl_kvt_pkg (slot_row_t).
module ttl_kvt_slot_ram #(
    parameter int DEPTH   = ttl_kvt_pkg::TABLE_ENTRIES,
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [IDX_W-1:0]             rd_addr,
    output ttl_kvt_pkg::slot_row_t       rd_row,
    input  logic                         wr_en,
    input  logic [IDX_W-1:0]             wr_addr,
    input  ttl_kvt_pkg::slot_row_t       wr_row
);

    ttl_kvt_pkg::slot_row_t mem [DEPTH];
    ttl_kvt_pkg::slot_row_t rd_row_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

>>> hdl/ttl_kvt_core.sv
// ttl_key_value_table_core: TTL key/value table, sweep controller over the slot memory.
// Depends on ttl_kvt_pkg, ttl_kvt_req_if, ttl_kvt_rsp_if and ttl_kvt_slot_ram.
//
//   channel | modport       | word carried
//   --------+---------------+----------------------------------------------------
//   req     | ttl_kvt_req_if.sink   | operation, entry_key, entry_value, expiry/current time
//   rsp     | ttl_kvt_rsp_if.source | status, read_value
//
// Each word sweeps every slot, one memory read per cycle, through S_SWEEP and S_DRAIN;
// the result is registered from S_FINISH, and the next request is taken only back in
// S_IDLE after that. The single read port of the slot memory sets this pace.
// After reset a clearing pass writes every slot invalid with req.ready low. A result
// left untaken holds the next one in S_FINISH until rsp.ready.
module ttl_key_value_table_core #(
    parameter int TABLE_ENTRIES = ttl_kvt_pkg::TABLE_ENTRIES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ttl_kvt_req_if.sink          req,
    ttl_kvt_rsp_if.source        rsp
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // state and counters
    ttl_kvt_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;

    // captured request word
    ttl_kvt_pkg::op_t                   op_reg, op_next;
    logic [ttl_kvt_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [ttl_kvt_pkg::VALUE_W-1:0]    val_reg, val_next;
    logic [ttl_kvt_pkg::TIME_W-1:0]     exp_reg, exp_next;
    logic [ttl_kvt_pkg::TIME_W-1:0]     now_reg, now_next;

    // sweep results
    logic                               found_reg, found_next;
    logic [IDX_W-1:0]                   found_idx_reg, found_idx_next;
    logic [ttl_kvt_pkg::VALUE_W-1:0]    hit_value_reg, hit_value_next;
    logic                               free_reg, free_next;
    logic [IDX_W-1:0]                   free_idx_reg, free_idx_next;

    // output register
    logic                               out_valid_reg, out_valid_next;
    ttl_kvt_pkg::status_t               out_status_reg, out_status_next;
    logic [ttl_kvt_pkg::VALUE_W-1:0]    out_value_reg, out_value_next;

    // memory ports
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    ttl_kvt_pkg::slot_row_t  rd_row;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    ttl_kvt_pkg::slot_row_t  wr_row;

    // control strobes
    logic                    accept;
    logic                    out_free;
    logic                    out_load;
    logic                    key_match;
    logic                    expired;
    ttl_kvt_pkg::slot_row_t  put_row;
    ttl_kvt_pkg::slot_row_t  kill_row;

    ttl_kvt_slot_ram #(
        .DEPTH (TABLE_ENTRIES)
    ) u_slot_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_row  (rd_row),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_row  (wr_row)
    );

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    // slot checks on the row read last cycle
    assign key_match = rd_row.valid && (rd_row.key == key_reg);
    assign expired   = rd_row.valid && (rd_row.expiry <= now_reg);

    assign put_row  = '{valid: 1'b1, key: key_reg, value: val_reg, expiry: exp_reg};
    assign kill_row = '{valid: 1'b0, key: rd_row.key, value: rd_row.value,
                        expiry: rd_row.expiry};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ttl_kvt_pkg::S_CLEAR:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ttl_kvt_pkg::S_IDLE;
                end
            end
            ttl_kvt_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ttl_kvt_pkg::S_SWEEP;
                end
            end
            ttl_kvt_pkg::S_SWEEP:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ttl_kvt_pkg::S_DRAIN;
                end
            end
            ttl_kvt_pkg::S_DRAIN:
            begin
                state_next = ttl_kvt_pkg::S_FINISH;
            end
            ttl_kvt_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ttl_kvt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ttl_kvt_pkg::S_CLEAR;
            end
        endcase
    end

    // FSM outputs: handshake, memory ports, sweep counter
    always_comb
    begin
        req.ready    = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;
        wr_en        = 1'b0;
        wr_addr      = chk_idx_reg;
        wr_row       = kill_row;
        out_load     = 1'b0;
        idx_next     = idx_reg;
        chk_vld_next = 1'b0;
        chk_idx_next = idx_reg;
        case (state_reg)
            ttl_kvt_pkg::S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_row   = '0;
                idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
            end
            ttl_kvt_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                idx_next  = '0;
            end
            ttl_kvt_pkg::S_SWEEP:
            begin
                rd_en        = 1'b1;
                chk_vld_next = 1'b1;
                idx_next     = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
                // a get drops expired slots as it passes them
                wr_en        = chk_vld_reg && (op_reg == ttl_kvt_pkg::OP_GET) && expired;
            end
            ttl_kvt_pkg::S_DRAIN:
            begin
                wr_en = chk_vld_reg && (op_reg == ttl_kvt_pkg::OP_GET) && expired;
            end
            ttl_kvt_pkg::S_FINISH:
            begin
                out_load = out_free;
                wr_row   = put_row;
                wr_addr  = found_reg ? found_idx_reg : free_idx_reg;
                wr_en    = out_free && (op_reg == ttl_kvt_pkg::OP_PUT)
                           && (found_reg || free_reg);
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // sweep bookkeeping and result word
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        exp_next        = exp_reg;
        now_next        = now_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        hit_value_next  = hit_value_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;

        // capture the request word
        if (accept)
        begin
            op_next    = ttl_kvt_pkg::op_t'(req.operation);
            key_next   = req.entry_key;
            val_next   = req.entry_value;
            exp_next   = req.expiry_time;
            now_next   = req.current_time;
            found_next = 1'b0;
            free_next  = 1'b0;
        end

        // get: first live key match; put: first key match, first free slot
        if (chk_vld_reg)
        begin
            if (op_reg == ttl_kvt_pkg::OP_GET)
            begin
                if (key_match && !expired && !found_reg)
                begin
                    found_next     = 1'b1;
                    hit_value_next = rd_row.value;
                end
            end
            else
            begin
                if (key_match && !found_reg)
                begin
                    found_next     = 1'b1;
                    found_idx_next = chk_idx_reg;
                end
                if (!rd_row.valid && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = chk_idx_reg;
                end
            end
        end

        // load the output register
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_value_next = ttl_kvt_pkg::NO_VALUE;
            if (op_reg == ttl_kvt_pkg::OP_GET)
            begin
                out_status_next = found_reg ? ttl_kvt_pkg::STAT_HIT : ttl_kvt_pkg::STAT_MISS;
                if (found_reg)
                begin
                    out_value_next = hit_value_reg;
                end
            end
            else
            begin
                out_status_next = (found_reg || free_reg) ? ttl_kvt_pkg::STAT_STORED
                                                          : ttl_kvt_pkg::STAT_FULL;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttl_kvt_pkg::S_CLEAR;
            idx_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= chk_idx_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        exp_reg        <= exp_next;
        now_reg        <= now_next;
        found_reg      <= found_next;
        found_idx_reg  <= found_idx_next;
        hit_value_reg  <= hit_value_next;
        free_reg       <= free_next;
        free_idx_reg   <= free_idx_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.read_value = out_value_reg;

`ifndef NO_ASSERTIONS
    // write-back never hits the slot being read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("slot memory read and write collide");

    // no request taken before the clearing pass is over
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ttl_kvt_pkg::S_CLEAR) |-> !req.ready)
        else $error("request accepted during clearing pass");

    // the check stage only runs behind a sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> (state_reg == ttl_kvt_pkg::S_SWEEP
                         || state_reg == ttl_kvt_pkg::S_DRAIN))
        else $error("slot check outside a sweep");

    // only a get hit carries a stored value
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ttl_kvt_pkg::STAT_HIT)
        |-> (rsp.read_value == ttl_kvt_pkg::NO_VALUE))
        else $error("non-hit result carries a value");

    // a new result is loaded only once the previous one has gone
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_valid_reg) |-> rsp.ready)
        else $error("result overwritten before it was taken");
`endif

endmodule
